[rtl/pwsem_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and sizes for the priority wakeup semaphore core.
package pwsem_pkg;

	// Waiter table depth and the widths that follow from it.
	localparam int WAITERS  = 16;
	localparam int AW       = $clog2(WAITERS);
	localparam int CW       = $clog2(WAITERS + 1);

	// Configuration port.
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;
	localparam logic REG_INITIAL_COUNT = 1'b0;

	localparam logic [15:0] COUNT_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		KIND_DOWN = 2'd0,
		KIND_TRY  = 2'd1,
		KIND_UP   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		STAT_GRANTED  = 3'd0,
		STAT_QUEUED   = 3'd1,
		STAT_REFUSED  = 3'd2,
		STAT_RELEASED = 3'd3,
		STAT_ERROR    = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_SCAN   = 2'd1,
		ST_SHIFT  = 2'd2,
		ST_FINISH = 2'd3
	} state_t;

	typedef struct packed {
		logic [7:0] thread;
		logic [5:0] prio;
	} entry_t;

	typedef struct packed {
		status_t     status;
		logic        woke_valid;
		logic [7:0]  woke_thread;
		logic [15:0] count_after;
		logic [4:0]  waiters_after;
	} result_t;

endpackage

[rtl/priority_wakeup_semaphore_core.sv]
`timescale 1ns / 1ps
// Counting semaphore with a waiter table, kept in arrival order, held in a synchronous memory.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid, in_stall, kind, thread_id,      | request in
//           | priority_req                              |
//   out     | out_valid, out_stall, status, woke_valid, | result out
//           | woke_thread, count_after, waiters_after   |
//   cfg     | psel, penable, pwrite, paddr, pwdata,     | register access
//           | prdata, pready                            |
//
// Down, try-down and an up with an empty table are decided in the accept cycle,
// staged in the result register and then moved to the output register; the
// next request is taken once that move is done. An up that wakes one of the
// waiters first makes one pass over the waiter memory to find the winner, and
// a second pass closes the gap when the winner is not the last slot; its result
// then follows the same path. Both passes are paced by the single read port
// of that memory with its registered read.
// Reset clears count, waiter count and control; the table needs no clearing.
// A finished result waits in the output register while the next request is
// accepted; the core only holds its own result when that register is stalled.

module priority_wakeup_semaphore_core
	import pwsem_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,

	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          kind,
	input  logic [7:0]          thread_id,
	input  logic [5:0]          priority_req,

	output logic                out_valid,
	input  logic                out_stall,
	output logic [2:0]          status,
	output logic                woke_valid,
	output logic [7:0]          woke_thread,
	output logic [15:0]         count_after,
	output logic [4:0]          waiters_after,

	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready
);

	// Architectural state.
	state_t       state_q, state_n;
	logic [15:0]  initial_count_q;
	logic [15:0]  count_q, count_n;
	logic [CW-1:0] wc_q, wc_n;

	// Waiter memory and its ports.
	entry_t       mem [WAITERS];
	logic         rd_en;
	logic [AW-1:0] rd_addr;
	entry_t       rd_data_s1;
	logic         rd_vld_s1;
	logic [AW-1:0] rd_idx_s1;
	logic         mem_we;
	logic [AW-1:0] mem_waddr;
	entry_t       mem_wdata;

	// Scan / compaction bookkeeping.
	logic [CW-1:0] issue_q;
	logic [AW-1:0] best_idx_q, best_idx_n;
	logic [5:0]    best_prio_q, best_prio_n;
	logic [7:0]    best_thread_q, best_thread_n;
	logic          take;
	logic          rd_last;
	logic          shift_needed;
	logic          start_scan;

	// Result staging and output register.
	result_t      res_q, res_n;
	logic         res_ld;
	result_t      out_q;
	logic         out_valid_q;
	logic         out_ld;

	logic         cfg_wr;

	// ---------------------------------------------------------------
	// Configuration port: a write loads the count and empties the table.
	// ---------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_INITIAL_COUNT);
	assign prdata = (paddr[2] == REG_INITIAL_COUNT) ?
		{{(PDATA_W-16){1'b0}}, initial_count_q} : '0;

	// ---------------------------------------------------------------
	// Scan compare: the first entry seeds the best; a later one wins only
	// on strictly higher priority, so ties keep the earliest queued.
	// ---------------------------------------------------------------
	assign take          = (rd_idx_s1 == '0) || (rd_data_s1.prio > best_prio_q);
	assign best_idx_n    = take ? rd_idx_s1         : best_idx_q;
	assign best_prio_n   = take ? rd_data_s1.prio   : best_prio_q;
	assign best_thread_n = take ? rd_data_s1.thread : best_thread_q;

	// Last read data of the current pass is back.
	assign rd_last      = rd_vld_s1 && ((CW'(rd_idx_s1) + CW'(1)) == wc_q);
	// Entries above the winner must move down one slot.
	assign shift_needed = (CW'(best_idx_n) + CW'(1)) != wc_q;

	// ---------------------------------------------------------------
	// Next state.
	// ---------------------------------------------------------------
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_n = start_scan ? ST_SCAN : ST_FINISH;
				end
			end
			ST_SCAN: begin
				if (rd_last) begin
					state_n = shift_needed ? ST_SHIFT : ST_FINISH;
				end
			end
			ST_SHIFT: begin
				if (rd_last) begin
					state_n = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_ld) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------
	// Datapath control: request decode, memory ports, commit of an up.
	// ---------------------------------------------------------------
	always_comb begin
		in_stall   = (state_q != ST_IDLE);
		rd_en      = 1'b0;
		rd_addr    = issue_q[AW-1:0];
		mem_we     = 1'b0;
		mem_waddr  = wc_q[AW-1:0];
		mem_wdata  = '{thread: thread_id, prio: priority_req};
		count_n    = count_q;
		wc_n       = wc_q;
		res_n      = res_q;
		res_ld     = 1'b0;
		start_scan = 1'b0;
		out_ld     = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					res_n.status      = STAT_ERROR;
					res_n.woke_valid  = 1'b0;
					res_n.woke_thread = '0;
					unique case (kind)
						KIND_DOWN: begin
							if (count_q != '0) begin
								count_n      = count_q - 16'd1;
								res_n.status = STAT_GRANTED;
							end else if (wc_q < CW'(WAITERS)) begin
								// Append the caller at the tail slot.
								mem_we       = 1'b1;
								wc_n         = wc_q + CW'(1);
								res_n.status = STAT_QUEUED;
							end
						end
						KIND_TRY: begin
							if (count_q != '0) begin
								count_n      = count_q - 16'd1;
								res_n.status = STAT_GRANTED;
							end else begin
								res_n.status = STAT_REFUSED;
							end
						end
						KIND_UP: begin
							if (count_q != COUNT_MAX) begin
								if (wc_q != '0) begin
									start_scan = 1'b1;
								end else begin
									count_n      = count_q + 16'd1;
									res_n.status = STAT_RELEASED;
								end
							end
						end
						default: res_n.status = STAT_ERROR;
					endcase
					res_n.count_after   = count_n;
					res_n.waiters_after = 5'(wc_n);
					res_ld              = !start_scan;
				end
			end
			ST_SCAN: begin
				rd_en = issue_q < wc_q;
				if (rd_last && !shift_needed) begin
					count_n = count_q + 16'd1;
					wc_n    = wc_q - CW'(1);
					res_n   = '{status: STAT_RELEASED, woke_valid: 1'b1,
						woke_thread: best_thread_n, count_after: count_q + 16'd1,
						waiters_after: 5'(wc_q - CW'(1))};
					res_ld  = 1'b1;
				end
			end
			ST_SHIFT: begin
				rd_en = issue_q < wc_q;
				if (rd_vld_s1) begin
					// Move the entry just read down over the gap.
					mem_we    = 1'b1;
					mem_waddr = rd_idx_s1 - AW'(1);
					mem_wdata = rd_data_s1;
				end
				if (rd_last) begin
					count_n = count_q + 16'd1;
					wc_n    = wc_q - CW'(1);
					res_n   = '{status: STAT_RELEASED, woke_valid: 1'b1,
						woke_thread: best_thread_q, count_after: count_q + 16'd1,
						waiters_after: 5'(wc_q - CW'(1))};
					res_ld  = 1'b1;
				end
			end
			ST_FINISH: begin
				out_ld = !out_valid_q || !out_stall;
			end
			default: ;
		endcase
	end

	// ---------------------------------------------------------------
	// Waiter memory: one write port, one registered read port. During
	// compaction the write trails the read by two slots, so no address
	// is read and written in the same cycle.
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	// ---------------------------------------------------------------
	// Control registers.
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			initial_count_q <= '0;
			count_q         <= '0;
			wc_q            <= '0;
			issue_q         <= '0;
			rd_vld_s1       <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			state_q   <= state_n;
			rd_vld_s1 <= rd_en;
			if (cfg_wr) begin
				initial_count_q <= pwdata[15:0];
				count_q         <= pwdata[15:0];
				wc_q            <= '0;
			end else begin
				count_q <= count_n;
				wc_q    <= wc_n;
			end
			// Advance the read pointer; restart it above the winner for compaction.
			if (start_scan) begin
				issue_q <= '0;
			end else if (state_q == ST_SCAN && rd_last) begin
				issue_q <= CW'(best_idx_n) + CW'(1);
			end else if (rd_en) begin
				issue_q <= issue_q + CW'(1);
			end
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_addr;
		if (state_q == ST_SCAN && rd_vld_s1) begin
			best_idx_q    <= best_idx_n;
			best_prio_q   <= best_prio_n;
			best_thread_q <= best_thread_n;
		end
		if (res_ld) begin
			res_q <= res_n;
		end
		if (out_ld) begin
			out_q <= res_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_q.status;
	assign woke_valid    = out_q.woke_valid;
	assign woke_thread   = out_q.woke_thread;
	assign count_after   = out_q.count_after;
	assign waiters_after = out_q.waiters_after;

	// ---------------------------------------------------------------
	// Assertions.
	// ---------------------------------------------------------------
	a_wc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		wc_q <= CW'(WAITERS))
		else $error("waiter count above table depth");

	a_rd_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (state_q == ST_SCAN || state_q == ST_SHIFT))
		else $error("memory read outside a scan or compaction pass");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && rd_en) |-> (mem_waddr != rd_addr))
		else $error("same waiter slot read and written in one cycle");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && out_valid_q && out_stall) |=> (state_q == ST_FINISH))
		else $error("pending result dropped while output stalled");

	a_rd_below_wc: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (CW'(rd_addr) < wc_q))
		else $error("read of a waiter slot at or above the fill level");

endmodule

[sim/semaphore_checker.sv]
`timescale 1ns / 1ps
// Checker that predicts and compares every semaphore result and register readback.
module semaphore_checker
	import pwsem_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,

	input  logic                in_valid,
	input  logic                in_stall,
	input  logic [1:0]          kind,
	input  logic [7:0]          thread_id,
	input  logic [5:0]          priority_req,

	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [2:0]          status,
	input  logic                woke_valid,
	input  logic [7:0]          woke_thread,
	input  logic [15:0]         count_after,
	input  logic [4:0]          waiters_after,

	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	input  logic [PDATA_W-1:0]  prdata,
	input  logic                pready,

	output int                  fail_count,
	output int                  outstanding
);

	localparam int REPORT_LIMIT = 10;

	logic [15:0] cfg_count;
	logic [15:0] sem_count;
	int          n_waiting;
	logic [7:0]  wait_thread [WAITERS];
	logic [5:0]  wait_prio [WAITERS];
	result_t     predicted_q [$];
	int          result_no;

	// Apply one request to the local semaphore copy and return its result.
	function automatic result_t predict_request(input logic [1:0] k, input logic [7:0] tid,
			input logic [5:0] prio);
		result_t r;
		int best;
		int i;
		r.status      = STAT_ERROR;
		r.woke_valid  = 1'b0;
		r.woke_thread = '0;
		case (k)
			KIND_DOWN: begin
				if (sem_count != 0) begin
					sem_count = sem_count - 16'd1;
					r.status = STAT_GRANTED;
				end else if (n_waiting < WAITERS) begin
					wait_thread[n_waiting] = tid;
					wait_prio[n_waiting]   = prio;
					n_waiting++;
					r.status = STAT_QUEUED;
				end
			end
			KIND_TRY: begin
				if (sem_count != 0) begin
					sem_count = sem_count - 16'd1;
					r.status = STAT_GRANTED;
				end else begin
					r.status = STAT_REFUSED;
				end
			end
			KIND_UP: begin
				if (sem_count != COUNT_MAX) begin
					if (n_waiting > 0) begin
						best = 0;
						for (i = 1; i < n_waiting; i++)
							if (wait_prio[i] > wait_prio[best])
								best = i;
						r.woke_valid  = 1'b1;
						r.woke_thread = wait_thread[best];
						for (i = best; i + 1 < n_waiting; i++) begin
							wait_thread[i] = wait_thread[i + 1];
							wait_prio[i]   = wait_prio[i + 1];
						end
						n_waiting--;
					end
					sem_count = sem_count + 16'd1;
					r.status = STAT_RELEASED;
				end
			end
			default: ;
		endcase
		r.count_after   = sem_count;
		r.waiters_after = 5'(n_waiting);
		return r;
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$display("%s", msg);
	endtask

	always @(posedge clk or negedge arst_n) begin : watch_channels
		result_t want;
		int reg_index;
		if (!arst_n) begin
			cfg_count   = '0;
			sem_count   = '0;
			n_waiting   = 0;
			result_no   = 0;
			fail_count  = 0;
			predicted_q.delete();
			outstanding = 0;
		end else begin
			reg_index = int'(paddr >> 2);
			if (psel && penable && pready && reg_index == int'(REG_INITIAL_COUNT)) begin
				if (pwrite) begin
					cfg_count = pwdata[15:0];
					sem_count = cfg_count;
					n_waiting = 0;
				end else if (prdata[15:0] !== cfg_count) begin
					note_failure($sformatf("initial_count readback: expected %0d, got %0d",
						cfg_count, prdata[15:0]));
				end
			end
			// Retire the oldest expectation before queueing a new one.
			if (out_valid && !out_stall) begin
				if (predicted_q.size() == 0) begin
					note_failure($sformatf("result with none expected: status %0d count %0d",
						status, count_after));
				end else begin
					want = predicted_q.pop_front();
					if (status !== want.status || woke_valid !== want.woke_valid ||
							woke_thread !== want.woke_thread ||
							count_after !== want.count_after ||
							waiters_after !== want.waiters_after)
						note_failure($sformatf({"result %0d: expected status %0d woke %0d/%0d ",
							"count %0d waiters %0d, got status %0d woke %0d/%0d count %0d ",
							"waiters %0d"}, result_no, want.status, want.woke_valid,
							want.woke_thread, want.count_after, want.waiters_after, status,
							woke_valid, woke_thread, count_after, waiters_after));
					result_no++;
				end
			end
			if (in_valid && !in_stall)
				predicted_q.push_back(predict_request(kind, thread_id, priority_req));
			outstanding = predicted_q.size();
		end
	end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// Top of the semaphore core testbench: clock, reset, stimulus, stall pattern and verdict.
module testbench;
	import pwsem_pkg::*;

	localparam int RESET_CYCLES    = 11;
	// Longest up: two passes over a full table plus pipeline, rounded up.
	localparam int DRAIN_CYCLES    = 64;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int RANDOM_PHASES   = 6;
	localparam int ITEMS_PER_PHASE = 84;
	// Kind code with no operation behind it; the core must flag it.
	localparam logic [1:0] KIND_BAD = 2'd3;
	localparam logic [PADDR_W-1:0] ADDR_INITIAL_COUNT = PADDR_W'(4 * int'(REG_INITIAL_COUNT));
	// One register past the last one; writes there must change nothing.
	localparam logic [PADDR_W-1:0] ADDR_UNUSED = ADDR_INITIAL_COUNT + PADDR_W'(4);

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;

	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         kind = KIND_DOWN;
	logic [7:0]         thread_id = '0;
	logic [5:0]         priority_req = '0;

	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [2:0]         status;
	logic               woke_valid;
	logic [7:0]         woke_thread;
	logic [15:0]        count_after;
	logic [4:0]         waiters_after;

	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int                 failures;
	int                 outstanding;
	int                 burst_left = 0;
	int                 idle_cycles = 0;
	logic [8:0]         stall_phase = '0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	priority_wakeup_semaphore_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.thread_id     (thread_id),
		.priority_req  (priority_req),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.woke_valid    (woke_valid),
		.woke_thread   (woke_thread),
		.count_after   (count_after),
		.waiters_after (waiters_after),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	semaphore_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.kind          (kind),
		.thread_id     (thread_id),
		.priority_req  (priority_req),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.woke_valid    (woke_valid),
		.woke_thread   (woke_thread),
		.count_after   (count_after),
		.waiters_after (waiters_after),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.fail_count    (failures),
		.outstanding   (outstanding)
	);

	// Receiver: cycle through four stall moods in turn - free flow,
	// coin flip, mostly stalled, and a fixed one-in-four stall.
	always @(posedge clk) begin
		stall_phase <= stall_phase + 9'd1;
		case (stall_phase[8:7])
			2'd0: out_stall <= 1'b0;
			2'd1: out_stall <= ($urandom_range(0, 1) == 0);
			2'd2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= (stall_phase[1:0] == 2'b11);
		endcase
	end

	// Watchdog: end the run when neither channel moves for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles == WATCHDOG_LIMIT) begin
				$display("priority_wakeup_semaphore_core: mismatch");
				$finish;
			end
		end
	end

	// Present one request and hold it until the core takes it. Call and
	// return right after a rising edge. When a burst runs out, drop valid
	// for a random gap first, then start a new burst of random length.
	task automatic send_request(input logic [1:0] k, input logic [7:0] tid,
			input logic [5:0] prio);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		in_valid     <= 1'b1;
		kind         <= k;
		thread_id    <= tid;
		priority_req <= prio;
		// in_stall only moves on a rising edge, so the falling edge shows
		// what the next rising edge will see.
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		burst_left--;
	endtask

	// Stop sending, wait for every expected result, then wait out a further
	// drain period.
	task automatic hold_until_drained();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(negedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One register access: setup cycle, then access cycle until pready.
	task automatic reg_access(input logic wr, input logic [PADDR_W-1:0] addr,
			input logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Load a new count with the core idle, then read it back.
	task automatic set_initial_count(input logic [15:0] value);
		hold_until_drained();
		reg_access(1'b1, ADDR_INITIAL_COUNT, PDATA_W'(value));
		reg_access(1'b0, ADDR_INITIAL_COUNT, '0);
	endtask

	initial begin : stimulus
		int          i;
		int          phase_no;
		int          item_no;
		int          roll;
		int          up_pct;
		logic [15:0] start_count;
		logic [1:0]  k;
		logic [7:0]  tid;
		logic [5:0]  prio;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty semaphore, refusal, up with nobody waiting, then
		// a full table with ties at the top priority and one thread queued
		// twice, a down on the full table, and wakeups.
		set_initial_count(16'd0);
		send_request(KIND_TRY, 8'h00, 6'd0);
		send_request(KIND_UP, 8'h5A, 6'h2A);
		send_request(KIND_DOWN, 8'hFF, 6'd63);
		for (i = 0; i < WAITERS; i++)
			send_request(KIND_DOWN, (i == 7) ? 8'hF2 : 8'(8'hF0 + i),
				(i % 3 == 1) ? 6'd63 : 6'(i));
		send_request(KIND_DOWN, 8'h00, 6'd63);

		// A write past the last register must leave count and table alone.
		hold_until_drained();
		reg_access(1'b1, ADDR_UNUSED, 32'hFFFF_FFFF);
		reg_access(1'b0, ADDR_INITIAL_COUNT, '0);
		send_request(KIND_UP, 8'h01, 6'd0);
		send_request(KIND_UP, 8'h02, 6'd0);

		// Directed: count at its top, up flagged as an error; bad kind; try grants.
		set_initial_count(COUNT_MAX);
		send_request(KIND_UP, 8'h33, 6'd5);
		send_request(KIND_BAD, 8'hCC, 6'd58);
		send_request(KIND_TRY, 8'h81, 6'd32);

		// Random phases: each starts from its own count and leans toward
		// ups or downs by its own amount. Small id and priority sets make
		// ties and repeated threads common.
		for (phase_no = 0; phase_no < RANDOM_PHASES; phase_no++) begin
			case (phase_no)
				0, 4: start_count = 16'd0;
				1: start_count = 16'd1;
				2: start_count = COUNT_MAX - 16'd1;
				3: start_count = 16'($urandom_range(2, 40));
				default: start_count = 16'($urandom_range(0, 65535));
			endcase
			set_initial_count(start_count);
			up_pct = $urandom_range(20, 55);
			for (item_no = 0; item_no < ITEMS_PER_PHASE; item_no++) begin
				roll = $urandom_range(0, 99);
				if (roll < 3)
					k = KIND_BAD;
				else if (roll < 3 + up_pct)
					k = KIND_UP;
				else if (roll < 18 + up_pct)
					k = KIND_TRY;
				else
					k = KIND_DOWN;
				tid  = $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom);
				prio = $urandom_range(0, 1) ? 6'($urandom_range(0, 3))
					: 6'($urandom_range(0, 63));
				send_request(k, tid, prio);
				// Now and then let the core run completely dry mid-phase.
				if ($urandom_range(0, 39) == 0)
					hold_until_drained();
			end
		end

		hold_until_drained();
		if (failures == 0)
			$display("priority_wakeup_semaphore_core: match");
		else
			$display("priority_wakeup_semaphore_core: mismatch");
		$finish;
	end

endmodule
